// ===== rtl/eased_led_fade_generator_assert.svh =====
// Assertion macros for the fade generator.
// Each expects clk and arst_n in scope.
`ifndef EASED_LED_FADE_GENERATOR_ASSERT_SVH
`define EASED_LED_FADE_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define EFG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fade generator check failed");

// Next-cycle implication.
`define EFG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fade generator check failed");

`endif

// ===== rtl/efg_pkg.sv =====
package efg_pkg;

	// Fixed geometry of the duty table and fields
	localparam int TABLE_DEPTH = 256;
	localparam int INDEX_BITS  = 8;
	localparam int DUTY_BITS   = 10;
	localparam int POS_BITS    = 32;
	localparam int STEP_BITS   = 16;

	// Function codes of an input request
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// Register map (word index)
	localparam logic [1:0] REG_STEP_SIZE  = 2'd0;
	localparam logic [1:0] REG_HALF_INDEX = 2'd1;
	localparam logic [1:0] REG_TOP_INDEX  = 2'd2;

	// Register reset values
	localparam logic [STEP_BITS-1:0]  STEP_SIZE_RST  = 16'd35;
	localparam logic [INDEX_BITS-1:0] HALF_INDEX_RST = 8'd127;
	localparam logic [INDEX_BITS-1:0] TOP_INDEX_RST  = 8'd254;

	typedef struct packed {
		logic                  func;
		logic [INDEX_BITS-1:0] table_addr;
		logic [DUTY_BITS-1:0]  table_value;
	} in_req_t;

	typedef struct packed {
		logic [DUTY_BITS-1:0]  duty;
		logic [INDEX_BITS-1:0] fade_index;
		logic                  descending;
		logic                  duty_changed;
	} out_rsp_t;

	// What one tick leaves for the table read stage
	typedef struct packed {
		logic                  changed;
		logic [INDEX_BITS-1:0] index;
		logic                  descending;
	} step_info_t;

endpackage

// ===== rtl/eased_led_fade_generator.sv =====
// Eased LED fade generator: takes one request per cycle while in_ready is high.
// A tick request moves the 16.16 position by the speed, updates speed, index
// and direction in the same cycle, and reads the duty table RAM at the new
// index; its result goes through the RAM's registered read (stage 1) into the
// output register. A table write request stores one entry and gives no result.
// Back-to-back ticks run at one per cycle as long as results are taken.
module eased_led_fade_generator import efg_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  in_req_t     in_req,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output out_rsp_t    out_rsp,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [STEP_BITS-1:0]  step_size_q;
	logic [INDEX_BITS-1:0] half_index_q;
	logic [INDEX_BITS-1:0] top_index_q;

	logic                  in_fire;
	logic                  tick;
	logic                  tbl_wr;
	logic                  s1_adv;
	logic                  valid_s1;
	step_info_t            info;
	step_info_t            info_s1;
	logic [DUTY_BITS-1:0]  rd_duty;
	logic [DUTY_BITS-1:0]  duty_sel;
	logic [DUTY_BITS-1:0]  cur_duty_q;
	logic                  out_valid_q;
	out_rsp_t              out_q;
	logic [1:0]            reg_sel;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q  <= STEP_SIZE_RST;
			half_index_q <= HALF_INDEX_RST;
			top_index_q  <= TOP_INDEX_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_STEP_SIZE:  step_size_q  <= pwdata[STEP_BITS-1:0];
				REG_HALF_INDEX: half_index_q <= pwdata[INDEX_BITS-1:0];
				REG_TOP_INDEX:  top_index_q  <= pwdata[INDEX_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_STEP_SIZE:  prdata = {{(32-STEP_BITS){1'b0}}, step_size_q};
			REG_HALF_INDEX: prdata = {{(32-INDEX_BITS){1'b0}}, half_index_q};
			REG_TOP_INDEX:  prdata = {{(32-INDEX_BITS){1'b0}}, top_index_q};
			default:        prdata = '0;
		endcase
	end

	// Handshake: stage 1 moves on when the output register is empty or being taken
	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_adv;
	assign in_fire  = in_valid && in_ready;
	assign tick     = in_fire && (in_req.func == FUNC_TICK);
	assign tbl_wr   = in_fire && (in_req.func == FUNC_WRITE);

	// Fade state update
	efg_core #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.step_size (step_size_q),
		.half_index(half_index_q),
		.top_index (top_index_q),
		.info      (info)
	);

	// Duty table
	efg_ram #(
		.WIDTH(DUTY_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (tbl_wr),
		.wr_addr(in_req.table_addr),
		.wr_data(in_req.table_value),
		.rd_en  (tick),
		.rd_addr(info.index),
		.rd_data(rd_duty)
	);

	// Stage 1: tick waiting on its table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= tick;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			info_s1 <= info;
		end
	end

	// Fresh entry on an index change, else the held duty
	assign duty_sel = info_s1.changed ? rd_duty : cur_duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_duty_q <= '0;
		end else if (valid_s1 && s1_adv) begin
			cur_duty_q <= duty_sel;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			out_q.duty         <= duty_sel;
			out_q.fade_index   <= info_s1.index;
			out_q.descending   <= info_s1.descending;
			out_q.duty_changed <= info_s1.changed;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

	// Checks
	`include "eased_led_fade_generator_assert.svh"

	`EFG_ASSERT_NEXT(a_tick_enters_s1, tick, valid_s1)
	`EFG_ASSERT_NEXT(a_s1_held_on_stall, valid_s1 && !s1_adv, valid_s1 && $stable(info_s1))
	`EFG_ASSERT_NEXT(a_s1_reaches_out, valid_s1 && s1_adv, out_valid_q)
	`EFG_ASSERT_NEXT(a_kept_duty, valid_s1 && s1_adv && !info_s1.changed,
		out_q.duty == $past(cur_duty_q))

endmodule

// ===== rtl/efg_ram.sv =====
module efg_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/efg_core.sv =====
module efg_core import efg_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick,
	input  logic [STEP_BITS-1:0]  step_size,
	input  logic [INDEX_BITS-1:0] half_index,
	input  logic [INDEX_BITS-1:0] top_index,
	output step_info_t            info
);

	logic [POS_BITS-1:0]   position_q;
	logic [POS_BITS-1:0]   speed_q;
	logic [INDEX_BITS-1:0] index_q;
	logic                  dir_q;

	logic [POS_BITS-1:0]   pos_next;
	logic [POS_BITS-1:0]   speed_next;
	logic [POS_BITS-1:0]   step_ext;
	logic [INDEX_BITS-1:0] idx;
	logic                  speed_up;
	logic                  dir_next;

	assign step_ext = {{(POS_BITS-STEP_BITS){1'b0}}, step_size};

	// Move the position, then bend the speed around the midpoint
	always_comb begin
		pos_next = dir_q ? (position_q - speed_q) : (position_q + speed_q);
		idx      = pos_next[FRACTION_BITS +: INDEX_BITS];
		speed_up = (idx < half_index) == !dir_q;
		if (idx == half_index) begin
			speed_next = speed_q;
		end else if (speed_up) begin
			speed_next = speed_q + step_ext;
		end else begin
			speed_next = speed_q - step_ext;
		end
		// Turn only on an index change; top check wins over zero
		dir_next = dir_q;
		if (idx != index_q) begin
			if (idx == top_index) begin
				dir_next = 1'b1;
			end else if (idx == '0) begin
				dir_next = 1'b0;
			end
		end
	end

	assign info.changed    = (idx != index_q);
	assign info.index      = idx;
	assign info.descending = dir_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			speed_q    <= '0;
			index_q    <= '0;
			dir_q      <= 1'b0;
		end else if (tick) begin
			position_q <= pos_next;
			speed_q    <= speed_next;
			index_q    <= idx;
			dir_q      <= dir_next;
		end
	end

endmodule
